// File: rtl/rlv_pkg.sv
// ----------------------------------------------------------------------------
// rlv_pkg
// shared constants, types and sequencer states for the rolling volatility block
// ----------------------------------------------------------------------------
package rlv_pkg;

    localparam int WINDOW_DEF = 30;

    localparam int PRICE_W  = 24;
    localparam int DAYS_W   = 9;
    localparam int VOL_W    = 32;
    localparam int RET_W    = 32;
    localparam int LOGP_W   = 40;
    localparam int SUM_W    = 40;
    localparam int SQSUM_W  = 64;

    localparam logic [DAYS_W-1:0] DAYS_RESET = 9'd252;
    localparam logic [27:0]       LN2_Q28    = 28'd186065279;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQ,
        ST_LN_F,
        ST_LN_E,
        ST_RET,
        ST_OLD,
        ST_NEW,
        ST_VOL,
        ST_DIV1,
        ST_DIFF,
        ST_DIV2,
        ST_ANN_LO,
        ST_ANN_HI,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [VOL_W-1:0] volatility;
        logic [RET_W-1:0] log_return;
        logic             window_ready;
    } result_t;

endpackage

// File: rtl/rlv_core.sv
// ----------------------------------------------------------------------------
// rlv_core
// sequencer around one shared multiplier and one shared subtractor: log of the
// price, return ring and running sums, two divisions and a square root
// ----------------------------------------------------------------------------
module rlv_core #(
    parameter int WINDOW = rlv_pkg::WINDOW_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rlv_pkg::PRICE_W-1:0] price,
    input  logic [rlv_pkg::DAYS_W-1:0]  days,
    input  logic                        res_ready,
    output logic                        idle,
    output logic                        res_valid,
    output rlv_pkg::result_t            res
);

    localparam int DEPTH = WINDOW - 1;
    localparam int CW    = $clog2(WINDOW);
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rlv_pkg::state_t state_reg, state_next;

    logic [31:0]                       x_reg, x_next;
    logic [4:0]                        e_reg, e_next;
    logic [29:0]                       f_reg, f_next;
    logic [5:0]                        iter_reg, iter_next;
    logic [63:0]                       acc_reg, acc_next;
    logic [rlv_pkg::LOGP_W-1:0]        lp_reg, lp_next;
    logic [rlv_pkg::LOGP_W-1:0]        prev_reg, prev_next;
    logic                              have_prev_reg, have_prev_next;
    logic signed [rlv_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [rlv_pkg::SQSUM_W-1:0]       sq_reg, sq_next;
    logic [PW-1:0]                     ptr_reg, ptr_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic signed [rlv_pkg::RET_W-1:0]  r_reg, r_next;
    logic [33:0]                       rem_reg, rem_next;
    logic [31:0]                       root_reg, root_next;
    logic [63:0]                       quo_reg, quo_next;
    logic                              sat_reg, sat_next;

    logic [31:0] ring_mem [DEPTH];
    logic [31:0] rd_reg;
    logic        ring_we;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [35:0] sub_a, sub_b;
    logic [36:0] sub_d;
    logic        sub_ge;

    logic [31:0]                  abs_old, abs_r;
    logic [rlv_pkg::SUM_W-1:0]    abs_sum;
    logic [63:0]                  lp_sum, annual_n;
    logic signed [40:0]           diff;
    logic [CW-1:0]                divisor;
    logic [CW:0]                  div_t;

    function automatic logic signed [rlv_pkg::SUM_W-1:0] SUM_W_EXT(input logic [31:0] v);
        SUM_W_EXT = {{(rlv_pkg::SUM_W - 32){v[31]}}, v};
    endfunction

    assign abs_old = rd_reg[31] ? (32'd0 - rd_reg) : rd_reg;
    assign abs_r   = r_reg[31] ? (32'd0 - r_reg) : r_reg;
    assign abs_sum = sum_reg[rlv_pkg::SUM_W-1] ? (-sum_reg) : sum_reg;
    assign divisor = (state_reg == rlv_pkg::ST_DIV2) ? (count_reg - CW'(1)) : count_reg;
    assign div_t   = {rem_reg[CW-1:0], quo_reg[63]};

    // shared operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        sub_a = '0;
        sub_b = '0;
        unique case (state_reg)
            rlv_pkg::ST_SQ: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            rlv_pkg::ST_LN_F: begin
                mul_a = {2'b00, f_reg};
                mul_b = {4'b0000, rlv_pkg::LN2_Q28};
            end
            rlv_pkg::ST_LN_E: begin
                mul_a = {27'd0, e_reg};
                mul_b = {4'b0000, rlv_pkg::LN2_Q28};
            end
            rlv_pkg::ST_OLD: begin
                mul_a = abs_old;
                mul_b = abs_old;
            end
            rlv_pkg::ST_NEW: begin
                mul_a = abs_r;
                mul_b = abs_r;
            end
            rlv_pkg::ST_VOL: begin
                mul_a = {2'b00, abs_sum[39:10]};
                mul_b = {2'b00, abs_sum[39:10]};
            end
            rlv_pkg::ST_ANN_LO: begin
                mul_a = quo_reg[31:0];
                mul_b = {23'd0, days};
            end
            rlv_pkg::ST_ANN_HI: begin
                mul_a = {16'd0, quo_reg[47:32]};
                mul_b = {23'd0, days};
            end
            rlv_pkg::ST_DIV1, rlv_pkg::ST_DIV2: begin
                sub_a = 36'(div_t);
                sub_b = 36'(divisor);
            end
            rlv_pkg::ST_SQRT: begin
                sub_a = {rem_reg, quo_reg[63:62]};
                sub_b = {2'b00, root_reg, 2'b01};
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign sub_d    = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = ~sub_d[36];
    assign lp_sum   = acc_reg + {prod[33:0], 30'd0} + 64'h0000_0000_0800_0000;
    assign annual_n = acc_reg + {prod[31:0], 32'd0};
    assign diff     = $signed({1'b0, lp_reg}) - $signed({1'b0, prev_reg});

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rlv_pkg::ST_IDLE:   if (start) state_next = rlv_pkg::ST_NORM;
            rlv_pkg::ST_NORM:   if (x_reg[23]) state_next = rlv_pkg::ST_SQ;
            rlv_pkg::ST_SQ:     if (iter_reg == 6'd29) state_next = rlv_pkg::ST_LN_F;
            rlv_pkg::ST_LN_F:   state_next = rlv_pkg::ST_LN_E;
            rlv_pkg::ST_LN_E:   state_next = rlv_pkg::ST_RET;
            rlv_pkg::ST_RET: begin
                priority if (!have_prev_reg) state_next = rlv_pkg::ST_VOL;
                else if (count_reg == CW'(DEPTH)) state_next = rlv_pkg::ST_OLD;
                else state_next = rlv_pkg::ST_NEW;
            end
            rlv_pkg::ST_OLD:    state_next = rlv_pkg::ST_NEW;
            rlv_pkg::ST_NEW:    state_next = rlv_pkg::ST_VOL;
            rlv_pkg::ST_VOL: begin
                if (count_reg < CW'(2)) state_next = rlv_pkg::ST_DONE;
                else state_next = rlv_pkg::ST_DIV1;
            end
            rlv_pkg::ST_DIV1:   if (iter_reg == 6'd63) state_next = rlv_pkg::ST_DIFF;
            rlv_pkg::ST_DIFF:   state_next = rlv_pkg::ST_DIV2;
            rlv_pkg::ST_DIV2:   if (iter_reg == 6'd63) state_next = rlv_pkg::ST_ANN_LO;
            rlv_pkg::ST_ANN_LO: begin
                if (quo_reg[63:48] != 16'd0 && days != '0) state_next = rlv_pkg::ST_DONE;
                else state_next = rlv_pkg::ST_ANN_HI;
            end
            rlv_pkg::ST_ANN_HI: begin
                if (annual_n[63:48] != 16'd0) state_next = rlv_pkg::ST_DONE;
                else state_next = rlv_pkg::ST_SQRT;
            end
            rlv_pkg::ST_SQRT:   if (iter_reg == 6'd31) state_next = rlv_pkg::ST_DONE;
            rlv_pkg::ST_DONE:   if (res_ready) state_next = rlv_pkg::ST_IDLE;
            default:            state_next = rlv_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        x_next         = x_reg;
        e_next         = e_reg;
        f_next         = f_reg;
        iter_next      = iter_reg;
        acc_next       = acc_reg;
        lp_next        = lp_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        r_next         = r_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        quo_next       = quo_reg;
        sat_next       = sat_reg;
        ring_we        = 1'b0;
        unique case (state_reg)
            rlv_pkg::ST_IDLE: begin
                if (start) begin
                    x_next    = (price == '0) ? 32'd1 : {8'd0, price};
                    e_next    = 5'd23;
                    f_next    = '0;
                    iter_next = '0;
                    root_next = '0;
                    sat_next  = 1'b0;
                end
            end
            rlv_pkg::ST_NORM: begin
                if (x_reg[23]) begin
                    x_next    = {x_reg[24:0], 7'd0};
                    iter_next = '0;
                end else begin
                    x_next = {x_reg[30:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
            end
            rlv_pkg::ST_SQ: begin
                if (prod[61]) begin
                    x_next = prod[62:31];
                    f_next = {f_reg[28:0], 1'b1};
                end else begin
                    x_next = prod[61:30];
                    f_next = {f_reg[28:0], 1'b0};
                end
                iter_next = iter_reg + 6'd1;
            end
            rlv_pkg::ST_LN_F: begin
                acc_next = prod;
            end
            rlv_pkg::ST_LN_E: begin
                lp_next = {4'd0, lp_sum[63:28]};
            end
            rlv_pkg::ST_RET: begin
                prev_next = lp_reg;
                if (!have_prev_reg) begin
                    have_prev_next = 1'b1;
                    r_next         = '0;
                end else if (diff[40:31] == 10'h000 || diff[40:31] == 10'h3FF) begin
                    r_next = diff[31:0];
                end else if (diff[40]) begin
                    r_next = 32'sh8000_0000;
                end else begin
                    r_next = 32'sh7FFF_FFFF;
                end
            end
            rlv_pkg::ST_OLD: begin
                sum_next = sum_reg - SUM_W_EXT(rd_reg);
                sq_next  = sq_reg - {20'd0, prod[63:20]};
            end
            rlv_pkg::ST_NEW: begin
                sum_next = sum_reg + SUM_W_EXT(r_reg);
                sq_next  = sq_reg + {20'd0, prod[63:20]};
                ring_we  = 1'b1;
                ptr_next = (ptr_reg == PW'(DEPTH - 1)) ? '0 : ptr_reg + PW'(1);
                if (count_reg != CW'(DEPTH)) count_next = count_reg + CW'(1);
            end
            rlv_pkg::ST_VOL: begin
                quo_next  = prod;
                rem_next  = '0;
                iter_next = '0;
            end
            rlv_pkg::ST_DIV1, rlv_pkg::ST_DIV2: begin
                if (sub_ge) rem_next = 34'(sub_d[CW-1:0]);
                else rem_next = 34'(div_t[CW-1:0]);
                quo_next  = {quo_reg[62:0], sub_ge};
                iter_next = iter_reg + 6'd1;
            end
            rlv_pkg::ST_DIFF: begin
                quo_next  = (sq_reg > quo_reg) ? (sq_reg - quo_reg) : 64'd0;
                rem_next  = '0;
                iter_next = '0;
            end
            rlv_pkg::ST_ANN_LO: begin
                if (quo_reg[63:48] != 16'd0 && days != '0) sat_next = 1'b1;
                acc_next = prod;
            end
            rlv_pkg::ST_ANN_HI: begin
                if (annual_n[63:48] != 16'd0) sat_next = 1'b1;
                quo_next  = {annual_n[47:0], 16'd0};
                rem_next  = '0;
                root_next = '0;
                iter_next = '0;
            end
            rlv_pkg::ST_SQRT: begin
                if (sub_ge) begin
                    rem_next  = sub_d[33:0];
                    root_next = {root_reg[30:0], 1'b1};
                end else begin
                    rem_next  = sub_a[33:0];
                    root_next = {root_reg[30:0], 1'b0};
                end
                quo_next  = {quo_reg[61:0], 2'b00};
                iter_next = iter_reg + 6'd1;
            end
            rlv_pkg::ST_DONE: begin
                ring_we = 1'b0;
            end
            default: begin
                ring_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rlv_pkg::ST_IDLE;
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            ptr_reg       <= '0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            prev_reg      <= prev_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        e_reg    <= e_next;
        f_reg    <= f_next;
        iter_reg <= iter_next;
        acc_reg  <= acc_next;
        lp_reg   <= lp_next;
        r_reg    <= r_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        quo_reg  <= quo_next;
        sat_reg  <= sat_next;
    end

    // return ring
    always_ff @(posedge aclk) begin
        if (ring_we) ring_mem[ptr_reg] <= r_reg;
        rd_reg <= ring_mem[ptr_reg];
    end

    assign idle             = (state_reg == rlv_pkg::ST_IDLE);
    assign res_valid        = (state_reg == rlv_pkg::ST_DONE);
    assign res.volatility   = sat_reg ? 32'hFFFF_FFFF : root_reg;
    assign res.log_return   = r_reg;
    assign res.window_ready = (count_reg == CW'(DEPTH));

endmodule

// File: rtl/rolling_log_return_volatility.sv
// ----------------------------------------------------------------------------
// rolling_log_return_volatility
// annualized volatility of daily log returns over a rolling price window
//
//   channel   dir  fields (lsb first)
//   s_*       in   tdata: close_price[23:0]
//   m_*       out  tdata: volatility[31:0], log_return[63:32]; tuser: window_ready
//   cfg_*     in   wdata: days_per_year[8:0]
//
// one request runs the normalize steps, the log squarings, two divider passes and
// the root steps on the shared units; with fewer than two returns held the
// divisions, the annualization and the square root are skipped
// s_tready is high only while the sequencer is idle
// a finished result sits in the output register and may wait on m_tready while
// the next request is taken; the sequencer holds its result until that clears
// reset clears the sums, count, pointer and previous price; the ring needs none
// ----------------------------------------------------------------------------
module rolling_log_return_volatility #(
    parameter int WINDOW = rlv_pkg::WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // close_price
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // volatility, log_return
    output logic [0:0]  m_tuser,   // window_ready
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata  // days_per_year
);

    logic [rlv_pkg::DAYS_W-1:0] days_reg;
    logic                       m_valid_reg, m_valid_next;
    rlv_pkg::result_t           m_res_reg, m_res_next;
    logic                       core_idle, core_valid, core_take, start;
    rlv_pkg::result_t           core_res;

    assign s_tready  = core_idle;
    assign start     = s_tvalid & core_idle;
    assign core_take = ~m_valid_reg | m_tready;

    rlv_core #(
        .WINDOW (WINDOW)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .price     (s_tdata),
        .days      (days_reg),
        .res_ready (core_take),
        .idle      (core_idle),
        .res_valid (core_valid),
        .res       (core_res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (core_valid && core_take) begin
            m_valid_next = 1'b1;
            m_res_next   = core_res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            days_reg    <= rlv_pkg::DAYS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) days_reg <= cfg_wdata;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.log_return, m_res_reg.volatility};
    assign m_tuser  = m_res_reg.window_ready;

endmodule

// File: tb/tb_rolling_log_return_volatility.sv
// ----------------------------------------------------------------------------
// tb_rolling_log_return_volatility
// self-checking bench for the rolling log-return volatility block: prices are
// streamed under several idle and stall mixes, an internal predictor computes
// the expected volatility, return and ready flag, and a scoreboard checks them
// ----------------------------------------------------------------------------
module tb_rolling_log_return_volatility;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_N = rlv_pkg::WINDOW_DEF - 1;

    class vol_scoreboard;
        logic signed [31:0] returns [RING_N];
        int unsigned slot, held;
        bit seen_price;
        logic [39:0] last_ln;
        logic signed [63:0] ret_total;
        logic [63:0] sq_total;
        logic [8:0] days;
        rlv_pkg::result_t pending[$];
        int errors, checked;

        function new();
            slot = 0; held = 0; seen_price = 0; last_ln = '0;
            ret_total = 0; sq_total = 0; days = rlv_pkg::DAYS_RESET;
            errors = 0; checked = 0;
        endfunction

        function logic [39:0] ln_price(logic [23:0] p);
            logic [63:0] x, f, l2;
            logic [127:0] prod;
            int e;
            e = 0; f = 0;
            if (p == 0) p = 1;
            while (e < 31 && (p >> (e + 1)) != 0) e++;
            x = 64'(p) << (30 - e);
            for (int i = 1; i <= 30; i++) begin
                x = (x * x) >> 30;
                if (x >= (64'd1 << 31)) begin
                    x = x >> 1;
                    f = f | (64'd1 << (30 - i));
                end
            end
            l2 = (64'(e) << 30) | f;
            prod = 128'(l2) * 128'(rlv_pkg::LN2_Q28) + (128'd1 << 27);
            return 40'(prod >> 28);
        endfunction

        function logic [63:0] square_ret(logic signed [31:0] r);
            logic [63:0] u;
            u = r < 0 ? 64'(-64'(r)) : 64'(r);
            return (u * u) >> 20;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] res, b;
            res = 0; b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function logic [31:0] annual_vol();
            logic [63:0] a, t, d, var_d, ann;
            if (held < 2) return 0;
            a = ret_total < 0 ? 64'(-ret_total) : 64'(ret_total);
            a = a >> 10;
            t = (a * a) / 64'(held);
            d = sq_total > t ? sq_total - t : 0;
            var_d = d / 64'(held - 1);
            ann = var_d * 64'(days);
            if ((ann >> 48) != 0) return 32'hFFFF_FFFF;
            return 32'(int_sqrt(ann << 16));
        endfunction

        function void note_price(logic [23:0] p);
            logic [39:0] lp;
            logic signed [63:0] diff;
            logic signed [31:0] r;
            rlv_pkg::result_t exp_r;
            lp = ln_price(p);
            r = 0;
            if (!seen_price) begin
                seen_price = 1;
            end else begin
                diff = $signed({24'd0, lp}) - $signed({24'd0, last_ln});
                if (diff > 64'sd2147483647) diff = 64'sd2147483647;
                if (diff < -64'sd2147483648) diff = -64'sd2147483648;
                r = 32'(diff);
                if (held >= RING_N) begin
                    ret_total -= 64'(returns[slot]);
                    sq_total -= square_ret(returns[slot]);
                end else begin
                    held++;
                end
                returns[slot] = r;
                ret_total += 64'(r);
                sq_total += square_ret(r);
                slot = (slot + 1) % RING_N;
            end
            last_ln = lp;
            exp_r.volatility = annual_vol();
            exp_r.log_return = r;
            exp_r.window_ready = held >= RING_N;
            pending.insert(pending.size(), exp_r);
        endfunction

        function void check_result(logic [63:0] data, logic ready);
            rlv_pkg::result_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $realtime, data);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            checked++;
            if (data[31:0] !== e.volatility) begin
                $display("%0t volatility exp %h got %h", $realtime, e.volatility, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.log_return) begin
                $display("%0t log_return exp %h got %h", $realtime, e.log_return,
                         data[63:32]);
                errors++;
            end
            if (ready !== e.window_ready) begin
                $display("%0t window_ready exp %b got %b", $realtime, e.window_ready, ready);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready;
    logic [23:0] s_tdata = '0;
    logic m_tvalid, m_tready = 0;
    logic [63:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_we = 0;
    logic [8:0] cfg_wdata = '0;

    vol_scoreboard sb = new();
    int send_idle_pct = 0, recv_stall_pct = 0;
    bit hold_off = 0;

    rolling_log_return_volatility dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
    end

    always @(negedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // valid stays high after an accept until the next call lowers or reloads it
    task automatic send_price(logic [23:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= p;
        do @(posedge aclk); while (!s_tready);
        sb.note_price(p);
        @(negedge aclk);
    endtask

    task automatic write_days(logic [8:0] d);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        cfg_we <= 1;
        cfg_wdata <= d;
        @(negedge aclk);
        cfg_we <= 0;
        sb.days = d;
    endtask

    function automatic logic [23:0] rand_price(logic [23:0] base);
        int unsigned k;
        k = $urandom_range(99);
        if (k < 5) return 24'($urandom_range(16777215, 1));
        if (k < 8) return 24'($urandom_range(3, 1));
        if (k < 10) return 24'hFFFFFF - 24'($urandom_range(3));
        if (base < 200) return base + 24'($urandom_range(20));
        return base + 24'($urandom_range(base / 50)) - 24'(base / 100);
    endfunction

    task automatic random_run(int count);
        logic [23:0] p;
        p = 24'($urandom_range(5000000, 100));
        repeat (count) begin
            p = rand_price(p);
            send_price(p);
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // directed: extremes, zero price, saturated returns
        send_price(24'd10000);
        send_price(24'd0);
        send_price(24'hFFFFFF);
        send_price(24'd1);
        send_price(24'hFFFFFF);
        send_price(24'd2);
        for (int i = 0; i < 24; i++) send_price(24'd10000 + 24'(i * 37));
        write_days(9'd1);
        random_run(150);
        write_days(9'd0);
        random_run(100);
        write_days(9'h1FF);
        for (int i = 0; i < 40; i++) send_price(i[0] ? 24'hFFFFFF : 24'd1);
        write_days(9'd366);
        send_idle_pct = 51;
        random_run(350);
        write_days(9'($urandom_range(365, 1)));
        send_idle_pct = 0;
        recv_stall_pct = 51;
        random_run(350);
        write_days(rlv_pkg::DAYS_RESET);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        random_run(350);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1;
                repeat (3000) @(negedge aclk);
                hold_off = 0;
            end
            random_run(20);
        join
        random_run(300);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        $display("checked %0d results over several day-count settings", sb.checked);
        $display("covered idle and stall mixes, extreme prices and a long output hold");
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

// File: files.f
rtl/rlv_pkg.sv
rtl/rlv_core.sv
rtl/rolling_log_return_volatility.sv
tb/tb_rolling_log_return_volatility.sv
